// File: rtl/assert_macros.svh
// Assertion macros for the grid broad-phase RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define UGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define UGB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ugb_pkg.sv
// Package of types and constants for the uniform grid broad-phase block.
package ugb_pkg;

	// Default sizes of the grid and its stores.
	localparam int unsigned GRID_CELLS_DEF  = 64;
	localparam int unsigned MAX_OBJECTS_DEF = 64;
	localparam int unsigned MAX_ENTRIES_DEF = 1024;

	// Fixed widths of the cell coordinate and object index fields, and the reset cell width.
	localparam int unsigned COORD_W = 8;
	localparam int unsigned OBJ_W   = 6;
	localparam logic [4:0]  CWL_RESET = 5'd10;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_FIN = 2'd1,
		MODE_QRY = 2'd2,
		MODE_CLR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OFF_GRID  = 3'd1,
		ST_FULL      = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_NOT_BUILT = 3'd4
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic [21:0]        extent_right;
		logic [21:0]        extent_left;
		logic [21:0]        extent_up;
		logic [21:0]        extent_down;
		logic [21:0]        radius;
	} req_t;

	typedef struct packed {
		logic [OBJ_W-1:0] object_index;
		logic             hit;
		status_t          status;
		logic             last;
	} rsp_t;

	// Inclusive cell box of an object or a query.
	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] y2;
	} box_t;

endpackage

// File: rtl/uniform_grid_broadphase_top.sv
// Top level of the uniform grid broad-phase block: control and stores.
//
// Requests arrive on req (valid/ready) and carry a mode: add, finish, query
// or clear. Responses leave on rsp (valid/ready); the last response of a
// request has last set. Add, finish and clear give one response; a query
// gives one per distinct object found, or one with hit clear if none.
// The cell width is written on cfg (valid/ready, always ready); the user
// must write it only while idle: the block does not enforce this. Cell
// counts and offsets live in one RAM, object boxes and the index store in
// two more; every cell visit of add and finish is a read followed by a
// write, and a query only reads. Add visits each covered cell. Finish runs
// a prefix sum over all cells, then per object reads its box and visits
// each covered cell. Query reads each scanned cell and each stored entry
// in it. Clear sweeps over all cells. After reset a clearing pass over all
// cells runs with req_ready low; configuration writes are taken throughout.
// A response waits in an output register, so the next request is taken
// while the receiver stalls; a query pauses its scan when both its
// pending and output registers are full.
module uniform_grid_broadphase_top import ugb_pkg::*; #(
	parameter int unsigned GRID_CELLS  = GRID_CELLS_DEF,
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);

`include "assert_macros.svh"

	localparam int unsigned NCELLS = GRID_CELLS * GRID_CELLS;
	localparam int unsigned AW     = $clog2(NCELLS);
	localparam int unsigned NW     = $clog2(MAX_OBJECTS + 1);
	localparam int unsigned OAW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int unsigned EW     = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned IW     = $clog2(MAX_ENTRIES);
	localparam int unsigned CEW    = NW + EW;

	typedef enum logic [16:0] {
		S_CLR      = 17'h00001,
		S_IDLE     = 17'h00002,
		S_BOX      = 17'h00004,
		S_ADD_CHK  = 17'h00008,
		S_A_RD     = 17'h00010,
		S_A_WR     = 17'h00020,
		S_PFX      = 17'h00040,
		S_PFX_LAST = 17'h00080,
		S_OBJ_RD   = 17'h00100,
		S_OBJ_WAIT = 17'h00200,
		S_F_RD     = 17'h00400,
		S_F_WR     = 17'h00800,
		S_Q_RD     = 17'h01000,
		S_Q_CELL   = 17'h02000,
		S_Q_IRD    = 17'h04000,
		S_Q_IDX    = 17'h08000,
		S_DONE     = 17'h10000
	} state_t;

	state_t             state_q;
	req_t               item_q;
	logic [4:0]         cwl_q;
	box_t               box_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [NW-1:0]      obj_cnt_q, o_q, k_q, cnt_q;
	logic [EW-1:0]      total_q, sum_q, first_q;
	logic               built_q, clr_rsp_q, pv_q;
	logic [MAX_OBJECTS-1:0] seen_q;
	logic [AW-1:0]      clr_q, pa_q;
	status_t            status_q;
	logic               p_valid_q;
	logic [OBJ_W-1:0]   p_idx_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// Box of the held request.
	box_t        bx;
	logic        bx_ok;
	logic        is_qry;
	logic [8:0]  wx, wy;
	logic [17:0] area;

	// RAM ports.
	logic            c_we;
	logic [AW-1:0]   c_waddr, c_raddr, caddr;
	logic [CEW-1:0]  c_wdata, c_rdata;
	logic [NW-1:0]   c_cnt;
	logic [EW-1:0]   c_first, pos;
	logic            i_we;
	logic [IW-1:0]   i_raddr;
	logic [OBJ_W-1:0] i_rdata;
	logic            b_we;
	box_t            b_rdata;

	logic o_free, push_ok, cell_last, seen_hit, rsp_load;

	assign is_qry = (item_q.mode == MODE_QRY);

	ugb_box_calc #(.GRID_CELLS(GRID_CELLS)) u_box (
		.cwl     (cwl_q),
		.cx      (item_q.center_x),
		.cy      (item_q.center_y),
		.er      (is_qry ? item_q.radius : item_q.extent_right),
		.el      (is_qry ? item_q.radius : item_q.extent_left),
		.eu      (is_qry ? item_q.radius : item_q.extent_up),
		.ed      (is_qry ? item_q.radius : item_q.extent_down),
		.box     (bx),
		.in_grid (bx_ok)
	);

	// Cell store: per cell a count and a start offset.
	ugb_ram #(.WIDTH(CEW), .DEPTH(NCELLS)) u_cell_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// Index store: object numbers in cell order.
	ugb_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_ENTRIES)) u_index_ram (
		.clk   (clk),
		.we    (i_we),
		.waddr (pos[IW-1:0]),
		.wdata (OBJ_W'(o_q)),
		.raddr (i_raddr),
		.rdata (i_rdata)
	);

	// Object box store.
	ugb_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_OBJECTS)) u_obj_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (obj_cnt_q[OAW-1:0]),
		.wdata (box_q),
		.raddr (o_q[OAW-1:0]),
		.rdata (b_rdata)
	);

	// Addressing and derived values.
	always_comb begin
		caddr     = AW'(32'(y_q) * 32'(GRID_CELLS) + 32'(x_q));
		c_cnt     = c_rdata[CEW-1:EW];
		c_first   = c_rdata[EW-1:0];
		pos       = c_first + EW'(c_cnt);
		i_raddr   = IW'(first_q + EW'(k_q));
		c_raddr   = (state_q == S_PFX) ? clr_q : caddr;
		wx        = {1'b0, box_q.x2} - {1'b0, box_q.x1} + 9'd1;
		wy        = {1'b0, box_q.y2} - {1'b0, box_q.y1} + 9'd1;
		area      = wx * wy;
		cell_last = (x_q == box_q.x2) && (y_q == box_q.y2);
		o_free    = !rsp_valid_q || rsp_ready;
		push_ok   = !p_valid_q || o_free;
		seen_hit  = seen_q[i_rdata[OAW-1:0]];
		rsp_load  = ((state_q == S_Q_IDX) && !seen_hit && push_ok && p_valid_q) ||
		            ((state_q == S_DONE) && o_free);
	end

	// RAM write controls.
	always_comb begin
		c_we    = 1'b0;
		c_waddr = caddr;
		c_wdata = {c_cnt + NW'(1), c_first};
		i_we    = 1'b0;
		b_we    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_wdata = '0;
			end
			S_PFX, S_PFX_LAST: begin
				c_we    = pv_q || (state_q == S_PFX_LAST);
				c_waddr = pa_q;
				c_wdata = {NW'(0), sum_q};
			end
			S_ADD_CHK: begin
				b_we = (32'(total_q) + 32'(area) <= 32'(MAX_ENTRIES));
			end
			S_A_WR: begin
				c_we = 1'b1;
			end
			S_F_WR: begin
				c_we = 1'b1;
				i_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwl_q <= CWL_RESET;
		end else if (cfg_valid) begin
			cwl_q <= cfg_data;
		end
	end

	// Held request and walk registers.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		unique case (state_q)
			S_BOX: begin
				box_q <= bx;
				x_q   <= bx.x1;
				y_q   <= bx.y1;
			end
			S_OBJ_WAIT: begin
				box_q <= b_rdata;
				x_q   <= b_rdata.x1;
				y_q   <= b_rdata.y1;
			end
			S_A_WR, S_F_WR: begin
				if (!cell_last) begin
					if (x_q == box_q.x2) begin
						x_q <= box_q.x1;
						y_q <= y_q + COORD_W'(1);
					end else begin
						x_q <= x_q + COORD_W'(1);
					end
				end
			end
			S_Q_CELL, S_Q_IDX: begin
				if (!cell_last && ((state_q == S_Q_CELL) ? (c_cnt == '0) :
				    ((seen_hit || push_ok) && (k_q + NW'(1) == cnt_q)))) begin
					if (x_q == box_q.x2) begin
						x_q <= box_q.x1;
						y_q <= y_q + COORD_W'(1);
					end else begin
						x_q <= x_q + COORD_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			obj_cnt_q   <= '0;
			total_q     <= '0;
			built_q     <= 1'b1;
			seen_q      <= '0;
			p_valid_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			pv_q        <= 1'b0;
			pa_q        <= '0;
			sum_q       <= '0;
			o_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			first_q     <= '0;
			status_q    <= ST_OK;
			p_idx_q     <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				// Clearing sweep over the cell store.
				S_CLR: begin
					if (clr_q == AW'(NCELLS - 1)) begin
						state_q <= clr_rsp_q ? S_DONE : S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					status_q <= ST_OK;
					if (req_valid) begin
						unique case (req.mode)
							MODE_ADD, MODE_QRY: state_q <= S_BOX;
							MODE_FIN: begin
								clr_q   <= '0;
								pv_q    <= 1'b0;
								sum_q   <= '0;
								state_q <= S_PFX;
							end
							MODE_CLR: begin
								obj_cnt_q <= '0;
								total_q   <= '0;
								seen_q    <= '0;
								built_q   <= 1'b1;
								clr_q     <= '0;
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLR;
							end
						endcase
					end
				end
				// Checks on the cell box.
				S_BOX: begin
					if (!is_qry) begin
						if (obj_cnt_q >= NW'(MAX_OBJECTS)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else if (!bx_ok) begin
							status_q <= ST_OFF_GRID;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_ADD_CHK;
						end
					end else if (!built_q) begin
						status_q <= ST_NOT_BUILT;
						state_q  <= S_DONE;
					end else if (!bx_ok) begin
						status_q <= ST_OFF_GRID;
						state_q  <= S_DONE;
					end else begin
						seen_q  <= '0;
						state_q <= S_Q_RD;
					end
				end
				S_ADD_CHK: begin
					if (b_we) begin
						total_q   <= EW'(32'(total_q) + 32'(area));
						p_idx_q   <= OBJ_W'(obj_cnt_q);
						p_valid_q <= 1'b1;
						obj_cnt_q <= obj_cnt_q + NW'(1);
						built_q   <= 1'b0;
						state_q   <= S_A_RD;
					end else begin
						status_q <= ST_OVERFLOW;
						state_q  <= S_DONE;
					end
				end
				S_A_RD: state_q <= S_A_WR;
				S_A_WR: state_q <= cell_last ? S_DONE : S_A_RD;
				// Prefix sum over the cells, one cell a cycle.
				S_PFX: begin
					if (pv_q) begin
						sum_q <= sum_q + EW'(c_cnt);
					end
					pa_q <= clr_q;
					pv_q <= 1'b1;
					if (clr_q == AW'(NCELLS - 1)) begin
						state_q <= S_PFX_LAST;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_PFX_LAST: begin
					o_q <= '0;
					if (obj_cnt_q == '0) begin
						built_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_OBJ_RD;
					end
				end
				S_OBJ_RD:   state_q <= S_OBJ_WAIT;
				S_OBJ_WAIT: state_q <= S_F_RD;
				S_F_RD:     state_q <= S_F_WR;
				// Place the object in the index store.
				S_F_WR: begin
					if (!cell_last) begin
						state_q <= S_F_RD;
					end else if (o_q + NW'(1) == obj_cnt_q) begin
						built_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						o_q     <= o_q + NW'(1);
						state_q <= S_OBJ_RD;
					end
				end
				S_Q_RD: state_q <= S_Q_CELL;
				S_Q_CELL: begin
					first_q <= c_first;
					cnt_q   <= c_cnt;
					k_q     <= '0;
					if (c_cnt != '0) begin
						state_q <= S_Q_IRD;
					end else begin
						state_q <= cell_last ? S_DONE : S_Q_RD;
					end
				end
				S_Q_IRD: state_q <= S_Q_IDX;
				// Report each object once; hold while no slot is free.
				S_Q_IDX: begin
					if (seen_hit || push_ok) begin
						if (!seen_hit) begin
							seen_q[i_rdata[OAW-1:0]] <= 1'b1;
							p_idx_q   <= i_rdata;
							p_valid_q <= 1'b1;
							if (p_valid_q) begin
								rsp_q       <= '{object_index: p_idx_q, hit: 1'b1,
								                 status: ST_OK, last: 1'b0};
								rsp_valid_q <= 1'b1;
							end
						end
						if (k_q + NW'(1) == cnt_q) begin
							state_q <= cell_last ? S_DONE : S_Q_RD;
						end else begin
							k_q     <= k_q + NW'(1);
							state_q <= S_Q_IRD;
						end
					end
				end
				// Final response of the request.
				S_DONE: begin
					if (o_free) begin
						if (p_valid_q) begin
							rsp_q <= '{object_index: p_idx_q, hit: 1'b1,
							           status: ST_OK, last: 1'b1};
						end else begin
							rsp_q <= '{object_index: '0, hit: 1'b0,
							           status: status_q, last: 1'b1};
						end
						rsp_valid_q <= 1'b1;
						p_valid_q   <= 1'b0;
						clr_rsp_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`UGB_ASSERT(a_idle_no_pending, req_ready |-> !p_valid_q, "idle with a response still pending")
	`UGB_ASSERT(a_obj_bound, obj_cnt_q <= NW'(MAX_OBJECTS), "object count above limit")
	`UGB_ASSERT(a_entry_bound, total_q <= EW'(MAX_ENTRIES), "entry total above limit")
	`UGB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")
	`UGB_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

// File: rtl/ugb_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module ugb_ram import ugb_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ugb_box_calc.sv
// Maps a centre and four extents onto an inclusive cell box.
module ugb_box_calc import ugb_pkg::*; #(
	parameter int unsigned GRID_CELLS = GRID_CELLS_DEF
) (
	input  logic [4:0]         cwl,
	input  logic signed [23:0] cx,
	input  logic signed [23:0] cy,
	input  logic [21:0]        er,
	input  logic [21:0]        el,
	input  logic [21:0]        eu,
	input  logic [21:0]        ed,
	output box_t               box,
	output logic               in_grid
);

	localparam int unsigned HALF = GRID_CELLS / 2;

	logic [5:0]         sh;
	logic signed [25:0] vx1, vx2, vy1, vy2;
	logic [26:0]        cx1, cx2, cy1, cy2;

	// Floor division by the cell width, then offset to the grid origin.
	function automatic logic [26:0] to_cell(input logic signed [25:0] v,
	                                        input logic [5:0] s);
		logic signed [25:0] q;
		q = v >>> s;
		return {q[25], q} + 27'(HALF);
	endfunction

	function automatic logic on_grid(input logic [26:0] c);
		return !c[26] && (c[25:0] < 26'(GRID_CELLS));
	endfunction

	// Box edges in raw coordinate steps.
	always_comb begin
		sh  = {1'b0, cwl} + 6'd8;
		vx1 = {{2{cx[23]}}, cx} - {4'b0, el};
		vx2 = {{2{cx[23]}}, cx} + {4'b0, er};
		vy1 = {{2{cy[23]}}, cy} - {4'b0, ed};
		vy2 = {{2{cy[23]}}, cy} + {4'b0, eu};
		cx1 = to_cell(vx1, sh);
		cx2 = to_cell(vx2, sh);
		cy1 = to_cell(vy1, sh);
		cy2 = to_cell(vy2, sh);
	end

	assign box.x1  = cx1[COORD_W-1:0];
	assign box.x2  = cx2[COORD_W-1:0];
	assign box.y1  = cy1[COORD_W-1:0];
	assign box.y2  = cy2[COORD_W-1:0];
	assign in_grid = on_grid(cx1) && on_grid(cx2) && on_grid(cy1) && on_grid(cy2);

endmodule
